/* hw/rtl/jdmt_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Joystick deadband and mode toggle: shared definitions
// Register widths, reset values, register indexes and the configuration
// bundle used by the block's modules.
// ----------------------------------------------------------------------------
package jdmt_pkg;

   localparam int SAMPLE_BITS_DEFAULT = 12;
   localparam int THRESHOLD_BITS      = 12;
   localparam int INTERVAL_BITS       = 16;
   localparam int TIME_BITS           = 32;
   localparam int CSR_DATA_BITS       = 16;
   localparam int CSR_INDEX_BITS      = 1;

   localparam logic [THRESHOLD_BITS-1:0] THRESHOLD_RESET = 12'd50;
   localparam logic [INTERVAL_BITS-1:0]  INTERVAL_RESET  = 16'd50;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_CHANGE_THRESHOLD = 1'b0,
      CSR_DEBOUNCE_INTERVAL = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [THRESHOLD_BITS-1:0] change_threshold;
      logic [INTERVAL_BITS-1:0]  debounce_interval_ms;
   } cfg_type;

endpackage

/* hw/rtl/joystick_deadband_and_mode_toggle.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Joystick deadband and mode toggle
// Holds two joystick axes behind a change threshold and toggles rotate mode
// on debounced rising edges of the mode button.
//
// Usage:
//   The req_ channel carries one beat per joystick sample: both axis samples,
//   the raw button level, a millisecond time stamp and a resync flag. The
//   rsp_ channel returns one beat per request with the held axes and the
//   current mode. A beat moves when valid is high and stall is low.
//   An accepted request goes through the input register, then the response
//   register; one beat per cycle is sustained while rsp_stall is low, set by
//   the input register, the single-pass update logic and the response register.
//   A stalled response register holds its beat; the input register then
//   fills and req_stall rises once it holds a beat, so no beat is dropped.
//   Synchronous reset empties both registers, clears the held axes, the
//   button state and the mode, and loads the register reset values.
//   The csr_ port is to be written by the user only while no beats are in flight, unchecked by the block.
// ----------------------------------------------------------------------------
module joystick_deadband_and_mode_toggle #(
   parameter int SAMPLE_BITS = jdmt_pkg::SAMPLE_BITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [jdmt_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [jdmt_pkg::CSR_DATA_BITS-1:0]  csr_wdata,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [SAMPLE_BITS-1:0]              req_sample_x,
   input  logic [SAMPLE_BITS-1:0]              req_sample_y,
   input  logic                                req_button_level,
   input  logic [jdmt_pkg::TIME_BITS-1:0]      req_time_ms,
   input  logic                                req_resync,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [SAMPLE_BITS-1:0]              rsp_motor_x,
   output logic [SAMPLE_BITS-1:0]              rsp_motor_y,
   output logic                                rsp_rotate_mode
);

   jdmt_pkg::cfg_type cfg;

   logic                           in_valid_ff;
   logic [SAMPLE_BITS-1:0]         in_sample_x_ff;
   logic [SAMPLE_BITS-1:0]         in_sample_y_ff;
   logic                           in_button_ff;
   logic [jdmt_pkg::TIME_BITS-1:0] in_time_ff;
   logic                           in_resync_ff;

   logic                           out_valid_ff;
   logic [SAMPLE_BITS-1:0]         out_motor_x_ff;
   logic [SAMPLE_BITS-1:0]         out_motor_y_ff;
   logic                           out_mode_ff;

   logic [SAMPLE_BITS-1:0]         held_x_in;
   logic [SAMPLE_BITS-1:0]         held_y_in;
   logic                           mode_in;
   logic                           advance;
   logic                           req_take;

   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   jdmt_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   jdmt_axis #(.SAMPLE_BITS(SAMPLE_BITS)) u_axis_x (
      .clock            (clock),
      .reset            (reset),
      .update           (advance),
      .sample           (in_sample_x_ff),
      .resync           (in_resync_ff),
      .change_threshold (cfg.change_threshold),
      .held_in          (held_x_in)
   );

   jdmt_axis #(.SAMPLE_BITS(SAMPLE_BITS)) u_axis_y (
      .clock            (clock),
      .reset            (reset),
      .update           (advance),
      .sample           (in_sample_y_ff),
      .resync           (in_resync_ff),
      .change_threshold (cfg.change_threshold),
      .held_in          (held_y_in)
   );

   jdmt_button u_button (
      .clock                (clock),
      .reset                (reset),
      .update               (advance),
      .button_level         (in_button_ff),
      .time_ms              (in_time_ff),
      .debounce_interval_ms (cfg.debounce_interval_ms),
      .mode_in              (mode_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_take) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_sample_x_ff <= req_sample_x;
         in_sample_y_ff <= req_sample_y;
         in_button_ff   <= req_button_level;
         in_time_ff     <= req_time_ms;
         in_resync_ff   <= req_resync;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_motor_x_ff <= held_x_in;
         out_motor_y_ff <= held_y_in;
         out_mode_ff    <= mode_in;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_motor_x     = out_motor_x_ff;
   assign rsp_motor_y     = out_motor_y_ff;
   assign rsp_rotate_mode = out_mode_ff;

endmodule

/* hw/rtl/jdmt_csr.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Joystick deadband and mode toggle: configuration registers
// Holds the change threshold and the debounce interval, written through a
// plain write port.
// ----------------------------------------------------------------------------
module jdmt_csr (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_we,
   input  logic [jdmt_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [jdmt_pkg::CSR_DATA_BITS-1:0]    csr_wdata,
   output jdmt_pkg::cfg_type                     cfg
);

   jdmt_pkg::cfg_type cfg_ff;
   jdmt_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (jdmt_pkg::csr_index_type'(csr_index))
            jdmt_pkg::CSR_CHANGE_THRESHOLD: begin
               cfg_in.change_threshold = csr_wdata[jdmt_pkg::THRESHOLD_BITS-1:0];
            end
            jdmt_pkg::CSR_DEBOUNCE_INTERVAL: begin
               cfg_in.debounce_interval_ms = csr_wdata[jdmt_pkg::INTERVAL_BITS-1:0];
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.change_threshold     <= jdmt_pkg::THRESHOLD_RESET;
         cfg_ff.debounce_interval_ms <= jdmt_pkg::INTERVAL_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

/* hw/rtl/jdmt_axis.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Joystick deadband and mode toggle: axis hold
// Keeps one held axis value and replaces it with a new sample only when the
// absolute change exceeds the threshold, or unconditionally on resync.
// ----------------------------------------------------------------------------
module jdmt_axis #(
   parameter int SAMPLE_BITS = jdmt_pkg::SAMPLE_BITS_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 update,
   input  logic [SAMPLE_BITS-1:0]               sample,
   input  logic                                 resync,
   input  logic [jdmt_pkg::THRESHOLD_BITS-1:0]  change_threshold,
   output logic [SAMPLE_BITS-1:0]               held_in
);

   localparam int CMP_BITS = (SAMPLE_BITS > jdmt_pkg::THRESHOLD_BITS) ?
                             SAMPLE_BITS : jdmt_pkg::THRESHOLD_BITS;

   logic [SAMPLE_BITS-1:0] held_ff;
   logic [SAMPLE_BITS-1:0] diff;
   logic                   exceeds;

   always_comb begin
      diff    = (sample > held_ff) ? (sample - held_ff) : (held_ff - sample);
      exceeds = CMP_BITS'(diff) > CMP_BITS'(change_threshold);
      held_in = (resync || exceeds) ? sample : held_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff <= '0;
      end else if (update) begin
         held_ff <= held_in;
      end
   end

endmodule

/* hw/rtl/jdmt_button.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Joystick deadband and mode toggle: button debounce
// Accepts a change of button level only after the debounce interval has
// strictly passed since the last accepted change; an accepted rising edge
// toggles rotate mode.
// ----------------------------------------------------------------------------
module jdmt_button (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                update,
   input  logic                                button_level,
   input  logic [jdmt_pkg::TIME_BITS-1:0]      time_ms,
   input  logic [jdmt_pkg::INTERVAL_BITS-1:0]  debounce_interval_ms,
   output logic                                mode_in
);

   logic                              stable_ff;
   logic                              stable_in;
   logic [jdmt_pkg::TIME_BITS-1:0]    last_change_ff;
   logic [jdmt_pkg::TIME_BITS-1:0]    last_change_in;
   logic                              mode_ff;
   logic [jdmt_pkg::TIME_BITS-1:0]    elapsed;
   logic                              take;

   always_comb begin
      elapsed        = time_ms - last_change_ff;
      take           = (button_level != stable_ff) &&
                       (elapsed > jdmt_pkg::TIME_BITS'(debounce_interval_ms));
      stable_in      = take ? button_level : stable_ff;
      last_change_in = take ? time_ms : last_change_ff;
      mode_in        = (take && button_level) ? !mode_ff : mode_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stable_ff      <= 1'b0;
         last_change_ff <= '0;
         mode_ff        <= 1'b0;
      end else if (update) begin
         stable_ff      <= stable_in;
         last_change_ff <= last_change_in;
         mode_ff        <= mode_in;
      end
   end

endmodule

/* hw/rtl/jdmt_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Joystick deadband and mode toggle: port checker
// Watches the top level's ports for reset, back-pressure and latency
// behaviour.
// ----------------------------------------------------------------------------
module jdmt_checker #(
   parameter int SAMPLE_BITS = jdmt_pkg::SAMPLE_BITS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_stall,
   input  logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  logic [SAMPLE_BITS-1:0] rsp_motor_x,
   input  logic [SAMPLE_BITS-1:0] rsp_motor_y,
   input  logic                   rsp_rotate_mode
);

   // The response channel is empty straight after reset.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response beat present after reset");

   // The request side is only held off while a response beat is stalled.
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("request stalled without downstream back-pressure");

   // An accepted request yields a response beat when the response side is unstalled.
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) ##1 !rsp_stall |=> rsp_valid)
      else $error("response beat missing after accepted request");

   // A stalled response beat holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_motor_x) &&
         $stable(rsp_motor_y) && $stable(rsp_rotate_mode)))
      else $error("stalled response beat changed");

endmodule

bind joystick_deadband_and_mode_toggle jdmt_checker #(
   .SAMPLE_BITS(SAMPLE_BITS)
) u_jdmt_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_motor_x     (rsp_motor_x),
   .rsp_motor_y     (rsp_motor_y),
   .rsp_rotate_mode (rsp_rotate_mode)
);
